// File: hdl/bgdrt_pkg.sv
// Shared types, constants and defaults for the button grid debounce reaction timer.
package bgdrt_pkg;

   localparam int DEF_GRID_ROWS  = 10;
   localparam int DEF_GRID_COLS  = 10;
   localparam int DEF_PORT_WIDTH = 16;

   localparam int MAP_FIELDS     = 10;
   localparam int MAX_COLS       = 16;
   localparam int ADDR_MAX_BITS  = 8;
   localparam int ROW_BITS       = 4;
   localparam int COL_FIELD_BITS = 4;
   localparam int PORT_BITS      = 16;
   localparam int STAMP_BITS     = 32;
   localparam int DEBOUNCE_BITS  = 16;
   localparam int MAP_BITS       = 40;
   localparam int CSR_DATA_BITS  = 40;
   localparam int CFG_INDEX_BITS = 1;

   localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [MAP_BITS-1:0]      COLUMN_MAP_RESET = 40'h98_7654_3210;

   localparam int CMD_FIFO_DEPTH = 2;
   localparam int RSP_FIFO_DEPTH = 4;

   typedef enum logic [CFG_INDEX_BITS-1:0] {
      CFG_DEBOUNCE   = 1'b0,
      CFG_COLUMN_MAP = 1'b1
   } cfg_index_type;

   typedef enum logic {
      KIND_SCAN = 1'b0,
      KIND_ARM  = 1'b1
   } kind_type;

   typedef struct packed {
      logic                      is_arm;
      logic [ROW_BITS-1:0]       row;
      logic [ADDR_MAX_BITS-1:0]  addr;
      logic [MAX_COLS-1:0]       pressed;
      logic [STAMP_BITS-1:0]     now;
   } cmd_type;

   typedef struct packed {
      logic [ROW_BITS-1:0]       press_row;
      logic [COL_FIELD_BITS-1:0] press_column;
      logic [STAMP_BITS-1:0]     reaction_ms;
      logic                      last_of_run;
   } rsp_type;

   typedef struct packed {
      logic                  raw;
      logic                  stable;
      logic [STAMP_BITS-1:0] stamp;
   } cell_type;

endpackage

// File: hdl/bgdrt_if.sv
// Valid/ready channel interfaces for scan and press transfers.
interface bgdrt_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   kind;
   logic [bgdrt_pkg::ROW_BITS-1:0]         row;
   logic [bgdrt_pkg::COL_FIELD_BITS-1:0]   column;
   logic [bgdrt_pkg::PORT_BITS-1:0]        port_bits;
   logic [bgdrt_pkg::STAMP_BITS-1:0]       now_ms;

   modport source (output valid, kind, row, column, port_bits, now_ms, input ready);
   modport sink   (input valid, kind, row, column, port_bits, now_ms, output ready);
endinterface

interface bgdrt_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [bgdrt_pkg::ROW_BITS-1:0]         press_row;
   logic [bgdrt_pkg::COL_FIELD_BITS-1:0]   press_column;
   logic [bgdrt_pkg::STAMP_BITS-1:0]       reaction_ms;
   logic                                   last_of_run;

   modport source (output valid, press_row, press_column, reaction_ms, last_of_run,
                   input ready);
   modport sink   (input valid, press_row, press_column, reaction_ms, last_of_run,
                   output ready);
endinterface

// File: hdl/button_grid_debounce_reaction_timer.sv
// Top level of the debounced button grid with per-cell reaction timers.
//
//   channel   direction  handshake          payload
//   req_ch    in         valid/ready        kind, row, column, port_bits, now_ms
//   rsp_ch    out        valid/ready        press_row, press_column, reaction_ms, last_of_run
//   csr_*     in         write enable only  csr_index, csr_data
//
// The back end's column sequencer steps a scan item through its GRID_COLS columns, one cell
// state read-modify-write per cycle while results have room; an arm item issues in one step.
// The final press of a scan goes through the execute register, the pending register and the
// result queue to rsp_ch; an earlier press waits for the next press or the last column.
// Reset clears all cell state at once through per-cell valid bits; items are
// accepted in the first cycle after reset.
// A stalled rsp_ch holds scan issue, not arm items, once queued and in-flight results reach the
// four-entry result queue; the two-entry command queue keeps accepting until it is full.
module button_grid_debounce_reaction_timer #(
   parameter int GRID_ROWS  = bgdrt_pkg::DEF_GRID_ROWS,
   parameter int GRID_COLS  = bgdrt_pkg::DEF_GRID_COLS,
   parameter int PORT_WIDTH = bgdrt_pkg::DEF_PORT_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   bgdrt_req_if.sink                              req_ch,
   bgdrt_rsp_if.source                            rsp_ch,
   input  logic                                   csr_write_enable,
   input  logic [bgdrt_pkg::CFG_INDEX_BITS-1:0]   csr_index,
   input  logic [bgdrt_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import bgdrt_pkg::*;

   localparam int CMD_W    = $bits(cmd_type);
   localparam int CNT_BITS = $clog2(CMD_FIFO_DEPTH + 1);

   logic                     front_valid;
   logic                     front_ready;
   cmd_type                  front_cmd;
   logic                     back_valid;
   logic                     back_ready;
   logic [CMD_W-1:0]         back_data;
   logic [CNT_BITS-1:0]      cmd_fill;
   logic [DEBOUNCE_BITS-1:0] settle_ms;

   bgdrt_front #(
      .GRID_ROWS  (GRID_ROWS),
      .GRID_COLS  (GRID_COLS),
      .PORT_WIDTH (PORT_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cmd_valid        (front_valid),
      .cmd_ready        (front_ready),
      .cmd_data         (front_cmd),
      .settle_ms        (settle_ms)
   );

   bgdrt_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_FIFO_DEPTH)
   ) u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_data),
      .fill       (cmd_fill)
   );

   bgdrt_back #(
      .GRID_ROWS (GRID_ROWS),
      .GRID_COLS (GRID_COLS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .settle_ms   (settle_ms),
      .cmd_valid   (back_valid && (cmd_fill != '0)),
      .cmd_ready   (back_ready),
      .cmd_data    (cmd_type'(back_data)),
      .rsp_ch      (rsp_ch)
   );

endmodule

// File: hdl/bgdrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bgdrt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 100,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 write_enable,
   input  logic [ADDR_BITS-1:0] write_addr,
   input  logic [WIDTH-1:0]     write_data,
   input  logic [ADDR_BITS-1:0] read_addr,
   output logic [WIDTH-1:0]     read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

// File: hdl/bgdrt_fifo.sv
// Small register FIFO used between front and back and ahead of the result port.
module bgdrt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  logic [WIDTH-1:0]    push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output logic [WIDTH-1:0]    pop_data,
   output logic [CNT_BITS-1:0] fill
);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push_fire;
   logic                pop_fire;

   assign push_ready = (count_ff != CNT_BITS'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign fill       = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hdl/bgdrt_front.sv
// Front end: configuration registers, item filtering and column decode.
module bgdrt_front #(
   parameter int GRID_ROWS  = bgdrt_pkg::DEF_GRID_ROWS,
   parameter int GRID_COLS  = bgdrt_pkg::DEF_GRID_COLS,
   parameter int PORT_WIDTH = bgdrt_pkg::DEF_PORT_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   bgdrt_req_if.sink                              req_ch,
   input  logic                                   csr_write_enable,
   input  logic [bgdrt_pkg::CFG_INDEX_BITS-1:0]   csr_index,
   input  logic [bgdrt_pkg::CSR_DATA_BITS-1:0]    csr_data,
   output logic                                   cmd_valid,
   input  logic                                   cmd_ready,
   output bgdrt_pkg::cmd_type                     cmd_data,
   output logic [bgdrt_pkg::DEBOUNCE_BITS-1:0]    settle_ms
);
   import bgdrt_pkg::*;

   logic [DEBOUNCE_BITS-1:0] debounce_ff, debounce_in;
   logic [MAP_BITS-1:0]      map_ff, map_in;
   logic [MAX_COLS-1:0]      pressed;
   logic                     row_ok;
   logic                     col_ok;
   logic                     is_arm;
   logic [ADDR_MAX_BITS-1:0] base_addr;

   always_comb begin
      debounce_in = debounce_ff;
      map_in      = map_ff;
      if (csr_write_enable) begin
         unique case (cfg_index_type'(csr_index))
            CFG_DEBOUNCE:   debounce_in = csr_data[DEBOUNCE_BITS-1:0];
            CFG_COLUMN_MAP: map_in      = csr_data[MAP_BITS-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         map_ff      <= COLUMN_MAP_RESET;
      end else begin
         debounce_ff <= debounce_in;
         map_ff      <= map_in;
      end
   end

   assign settle_ms = debounce_ff;

   for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
      if (c < GRID_COLS) begin : g_used
         logic [COL_FIELD_BITS-1:0] port_bit;
         if (c < MAP_FIELDS) begin : g_mapped
            assign port_bit = map_ff[COL_FIELD_BITS*c +: COL_FIELD_BITS];
         end else begin : g_direct
            assign port_bit = COL_FIELD_BITS'(c);
         end
         assign pressed[c] = (6'(port_bit) < 6'(PORT_WIDTH)) && !req_ch.port_bits[port_bit];
      end else begin : g_unused
         assign pressed[c] = 1'b0;
      end
   end

   assign is_arm    = (kind_type'(req_ch.kind) == KIND_ARM);
   assign row_ok    = ({1'b0, req_ch.row} < 5'(GRID_ROWS));
   assign col_ok    = ({1'b0, req_ch.column} < 5'(GRID_COLS));
   assign base_addr = ADDR_MAX_BITS'(req_ch.row) * ADDR_MAX_BITS'(GRID_COLS);

   // drop items that address no cell
   assign req_ch.ready = cmd_ready;
   assign cmd_valid    = req_ch.valid && row_ok && (!is_arm || col_ok);

   always_comb begin
      cmd_data.is_arm  = is_arm;
      cmd_data.row     = req_ch.row;
      cmd_data.addr    = is_arm ? base_addr + ADDR_MAX_BITS'(req_ch.column) : base_addr;
      cmd_data.pressed = pressed;
      cmd_data.now     = req_ch.now_ms;
   end

endmodule

// File: hdl/bgdrt_back.sv
// Back end: per-column sequencer, cell state and arm stamp memories, press results.
module bgdrt_back #(
   parameter int GRID_ROWS = bgdrt_pkg::DEF_GRID_ROWS,
   parameter int GRID_COLS = bgdrt_pkg::DEF_GRID_COLS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [bgdrt_pkg::DEBOUNCE_BITS-1:0]    settle_ms,
   input  logic                                   cmd_valid,
   output logic                                   cmd_ready,
   input  bgdrt_pkg::cmd_type                     cmd_data,
   bgdrt_rsp_if.source                            rsp_ch
);
   import bgdrt_pkg::*;

   localparam int CELLS     = GRID_ROWS * GRID_COLS;
   localparam int CELL_BITS = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int COL_BITS  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
   localparam int CNT_BITS  = $clog2(RSP_FIFO_DEPTH + 1);
   localparam int SUM_BITS  = CNT_BITS + 2;
   localparam int CELL_W    = $bits(cell_type);
   localparam int RSP_W     = $bits(rsp_type);

   // issue stage
   logic                 busy_ff, busy_in;
   cmd_type              cmd_ff, cmd_in;
   logic [COL_BITS-1:0]  col_ff, col_in;
   cmd_type              active;
   logic [COL_BITS-1:0]  col;
   logic                 credit_ok;
   logic                 issue;
   logic                 a_done;
   logic                 a_scan;
   logic [CELL_BITS-1:0] a_addr;
   logic [CNT_BITS-1:0]  out_fill;

   // valid bits
   logic [CELLS-1:0]     cell_valid_ff, cell_valid_in;
   logic [CELLS-1:0]     arm_valid_ff, arm_valid_in;

   // execute stage
   logic                      b_valid_ff, b_valid_in;
   logic [CELL_BITS-1:0]      b_addr_ff;
   logic [ROW_BITS-1:0]       b_row_ff;
   logic [COL_BITS-1:0]       b_col_ff;
   logic                      b_pressed_ff;
   logic [STAMP_BITS-1:0]     b_now_ff;
   logic                      b_last_ff;
   logic                      b_cell_valid_ff;
   logic                      b_arm_valid_ff;
   logic                      fwd_hit_ff, fwd_hit_in;
   cell_type                  fwd_data_ff;
   logic [CELL_W-1:0]         cell_rdata;
   logic [STAMP_BITS-1:0]     arm_rdata;
   cell_type                  cell_old;
   cell_type                  cell_new;
   logic [STAMP_BITS-1:0]     arm_old;
   logic [STAMP_BITS-1:0]     elapsed;
   logic                      held;
   logic                      change;
   logic                      b_press;
   rsp_type                   press_rsp;

   // pending result
   logic                      pend_valid_ff, pend_valid_in;
   logic                      pend_final_ff, pend_final_in;
   rsp_type                   pend_ff, pend_in;
   logic                      push;
   rsp_type                   push_rsp;
   rsp_type                   out_rsp;
   logic [RSP_W-1:0]          out_data;
   logic                      out_push_ready;

   assign active = busy_ff ? cmd_ff : cmd_data;
   assign col    = busy_ff ? col_ff : '0;
   assign a_scan = !active.is_arm;

   // hold scan column issue until every result in flight has a free slot
   assign credit_ok = (SUM_BITS'(out_fill) + SUM_BITS'(pend_valid_ff) + SUM_BITS'(b_valid_ff)
                       + SUM_BITS'(1)) <= SUM_BITS'(RSP_FIFO_DEPTH);
   assign issue     = (busy_ff || cmd_valid) && (active.is_arm || credit_ok);
   assign a_done    = active.is_arm || (col == COL_BITS'(GRID_COLS - 1));
   assign cmd_ready = !busy_ff && issue;
   assign a_addr    = active.addr[CELL_BITS-1:0] + (a_scan ? CELL_BITS'(col) : '0);

   always_comb begin
      busy_in = busy_ff;
      cmd_in  = cmd_ff;
      col_in  = col_ff;
      if (issue) begin
         busy_in = !a_done;
         col_in  = col + 1'b1;
         if (!busy_ff) begin
            cmd_in = cmd_data;
         end
      end
   end

   always_comb begin
      cell_valid_in = cell_valid_ff;
      arm_valid_in  = arm_valid_ff;
      if (b_valid_ff) begin
         cell_valid_in[b_addr_ff] = 1'b1;
      end
      if (issue && active.is_arm) begin
         arm_valid_in[a_addr] = 1'b1;
      end
   end

   assign b_valid_in = issue && a_scan;
   assign fwd_hit_in = b_valid_ff && (b_addr_ff == a_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         b_valid_ff    <= 1'b0;
         cell_valid_ff <= '0;
         arm_valid_ff  <= '0;
         pend_valid_ff <= 1'b0;
         pend_final_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         b_valid_ff    <= b_valid_in;
         cell_valid_ff <= cell_valid_in;
         arm_valid_ff  <= arm_valid_in;
         pend_valid_ff <= pend_valid_in;
         pend_final_ff <= pend_final_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff          <= cmd_in;
      col_ff          <= col_in;
      b_addr_ff       <= a_addr;
      b_row_ff        <= active.row;
      b_col_ff        <= col;
      b_pressed_ff    <= active.pressed[COL_FIELD_BITS'(col)];
      b_now_ff        <= active.now;
      b_last_ff       <= a_done;
      b_cell_valid_ff <= cell_valid_ff[a_addr];
      b_arm_valid_ff  <= arm_valid_ff[a_addr];
      fwd_hit_ff      <= fwd_hit_in;
      fwd_data_ff     <= cell_new;
      pend_ff         <= pend_in;
   end

   bgdrt_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cell_ram (
      .clock        (clock),
      .write_enable (b_valid_ff),
      .write_addr   (b_addr_ff),
      .write_data   (cell_new),
      .read_addr    (a_addr),
      .read_data    (cell_rdata)
   );

   bgdrt_ram #(
      .WIDTH (STAMP_BITS),
      .DEPTH (CELLS)
   ) u_arm_ram (
      .clock        (clock),
      .write_enable (issue && active.is_arm),
      .write_addr   (a_addr),
      .write_data   (active.now),
      .read_addr    (a_addr),
      .read_data    (arm_rdata)
   );

   always_comb begin
      if (fwd_hit_ff) begin
         cell_old = fwd_data_ff;
      end else if (b_cell_valid_ff) begin
         cell_old = cell_type'(cell_rdata);
      end else begin
         cell_old = '0;
      end
      arm_old = b_arm_valid_ff ? arm_rdata : '0;

      cell_new.raw   = b_pressed_ff;
      cell_new.stamp = (b_pressed_ff != cell_old.raw) ? b_now_ff : cell_old.stamp;
      elapsed        = b_now_ff - cell_new.stamp;
      held           = (elapsed >= STAMP_BITS'(settle_ms));
      change         = held && (cell_old.stable != b_pressed_ff);
      cell_new.stable = change ? b_pressed_ff : cell_old.stable;
      b_press        = b_valid_ff && change && b_pressed_ff;

      press_rsp.press_row    = b_row_ff;
      press_rsp.press_column = COL_FIELD_BITS'(b_col_ff);
      press_rsp.reaction_ms  = b_now_ff - arm_old;
      press_rsp.last_of_run  = 1'b0;
   end

   // hold each press until the next press or the last column so the final press of a scan gets the last flag
   assign push = pend_valid_ff && (pend_final_ff || b_press);

   always_comb begin
      push_rsp             = pend_ff;
      push_rsp.last_of_run = pend_final_ff;
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_final_in = pend_final_ff;
      pend_in       = pend_ff;
      priority if (b_press) begin
         pend_valid_in = 1'b1;
         pend_final_in = b_last_ff;
         pend_in       = press_rsp;
      end else if (push) begin
         pend_valid_in = 1'b0;
         pend_final_in = 1'b0;
      end else if (b_valid_ff && b_last_ff && pend_valid_ff) begin
         pend_final_in = 1'b1;
      end
   end

   bgdrt_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_FIFO_DEPTH)
   ) u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push && out_push_ready),
      .push_ready (out_push_ready),
      .push_data  (push_rsp),
      .pop_valid  (rsp_ch.valid),
      .pop_ready  (rsp_ch.ready),
      .pop_data   (out_data),
      .fill       (out_fill)
   );

   assign out_rsp             = rsp_type'(out_data);
   assign rsp_ch.press_row    = out_rsp.press_row;
   assign rsp_ch.press_column = out_rsp.press_column;
   assign rsp_ch.reaction_ms  = out_rsp.reaction_ms;
   assign rsp_ch.last_of_run  = out_rsp.last_of_run;

endmodule

// File: hdl/bgdrt_checker.sv
// Port checker for the result channel, bound to the top level.
module bgdrt_checker #(
   parameter int GRID_ROWS = bgdrt_pkg::DEF_GRID_ROWS,
   parameter int GRID_COLS = bgdrt_pkg::DEF_GRID_COLS
) (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic [bgdrt_pkg::ROW_BITS-1:0]         press_row,
   input logic [bgdrt_pkg::COL_FIELD_BITS-1:0]   press_column,
   input logic [bgdrt_pkg::STAMP_BITS-1:0]       reaction_ms,
   input logic                                   last_of_run
);

   a_reset_drains: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_cell_in_grid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, press_row} < 5'(GRID_ROWS)) &&
                    ({1'b0, press_column} < 5'(GRID_COLS)))
      else $error("press outside the grid");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(press_row) && $stable(press_column) &&
                                  $stable(reaction_ms) && $stable(last_of_run))
      else $error("result changed while stalled");

endmodule

bind button_grid_debounce_reaction_timer bgdrt_checker #(
   .GRID_ROWS (GRID_ROWS),
   .GRID_COLS (GRID_COLS)
) u_bgdrt_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .press_row    (rsp_ch.press_row),
   .press_column (rsp_ch.press_column),
   .reaction_ms  (rsp_ch.reaction_ms),
   .last_of_run  (rsp_ch.last_of_run)
);
